### rtl/core/sitda_pkg.sv
// Shared types and constants of the signed integer to decimal text converter.
package sitda_pkg;

  // Widths of the integer, the character and the decimal digits.
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 7;
  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

  // Conversion pipeline: binary bits handled per stage and number of stages.
  localparam int STAGE_BITS = 8;
  localparam int NUM_STAGES = VALUE_W / STAGE_BITS;

  // Character codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  // One item in flight through the conversion pipeline.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd;
  } conv_t;

endpackage

### rtl/core/sitda_in_if.sv
// Input channel: one signed integer per item.
interface sitda_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitda_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/core/sitda_out_if.sv
// Output channel: one ASCII character per item, with an end-of-run flag.
interface sitda_out_if;
  logic                              valid;
  logic                              ready;
  logic [sitda_pkg::CHAR_W-1:0]      character;
  logic                              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

### rtl/core/sitda_dabble.sv
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
module sitda_dabble (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sitda_pkg::conv_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sitda_pkg::conv_t  out_data
);
  import sitda_pkg::*;

  // Runs STAGE_BITS iterations: correct each digit, then shift in the next binary bit.
  function automatic conv_t dabble(input conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < STAGE_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.mag[VALUE_W-1]};
      r.mag = {r.mag[VALUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  conv_t stage_result;

  assign stage_result = dabble(in_data);
  assign in_ready     = !out_valid || out_ready;

  // Stage register; it advances whenever the next stage can take its item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= stage_result;
    end
  end

endmodule

### rtl/core/sitda_serializer.sv
// Emits an item's sign and significant decimal digits, one character per unstalled cycle.
module sitda_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sitda_pkg::conv_t in_data,
  sitda_out_if.source      dout
);
  import sitda_pkg::*;

  logic                   busy;
  logic                   neg_pend;
  logic [DIGIT_IDX_W-1:0] idx;
  logic [3:0]             digit_q [NUM_DIGITS];
  logic [DIGIT_IDX_W-1:0] lead;
  logic                   emit;
  logic                   out_valid;
  logic [CHAR_W-1:0]      character;
  logic                   last;

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    lead = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (in_data.bcd[4*d +: 4] != 4'd0) begin
        lead = DIGIT_IDX_W'(d);
      end
    end
  end

  assign in_ready = !busy;
  assign emit     = busy && (!out_valid || dout.ready);

  assign dout.valid     = out_valid;
  assign dout.character = character;
  assign dout.last      = last;

  // Load an item, then step through its characters into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (neg_pend) begin
          character <= ASCII_MINUS;
          last      <= 1'b0;
          neg_pend  <= 1'b0;
        end else begin
          character <= ASCII_ZERO + {3'b000, digit_q[idx]};
          last      <= (idx == '0);
          if (idx == '0) begin
            busy <= 1'b0;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (!busy && in_valid) begin
        busy     <= 1'b1;
        neg_pend <= in_data.neg;
        idx      <= lead;
        for (int d = 0; d < NUM_DIGITS; d++) begin
          digit_q[d] <= in_data.bcd[4*d +: 4];
        end
      end
    end
  end

endmodule

### rtl/core/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII converter. Each input item is a two's complement
// integer; the block sends its decimal text as a run of characters, one output item per
// character: a '-' first for negative values, then the digits most significant first with
// no leading zeros ("0" for zero, "-2147483648" for the most negative value). The last
// character of a run carries last = 1. An entry register forms sign and magnitude, four
// register stages perform the shift-and-add-3 conversion eight bits at a time, and a
// serializer feeds an output register. The serializer sets the rate: it loads one item of
// 1 to 11 characters at a time and takes no new item until it has sent the last of them.
// Stalls on the output hold every stage without loss.
module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  sitda_in_if.sink    din,
  sitda_out_if.source dout
);
  import sitda_pkg::*;

  logic               ent_valid;
  conv_t              ent_data;
  logic [VALUE_W-1:0] value_u;
  logic               value_neg;

  conv_t stg_data  [NUM_STAGES+1];
  logic  stg_valid [NUM_STAGES+1];
  logic  stg_ready [NUM_STAGES+1];

  // Entry register: sign and magnitude; the magnitude of the most negative value fits unsigned.
  assign value_u   = din.value;
  assign value_neg = value_u[VALUE_W-1];
  assign din.ready = !ent_valid || stg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (din.ready) begin
      ent_valid <= din.valid;
    end
    if (din.ready && din.valid) begin
      ent_data.neg <= value_neg;
      ent_data.mag <= value_neg ? (~value_u + 1'b1) : value_u;
      ent_data.bcd <= '0;
    end
  end

  assign stg_data[0]  = ent_data;
  assign stg_valid[0] = ent_valid;

  // Conversion pipeline.
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    sitda_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  // Character output.
  sitda_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid[NUM_STAGES]),
    .in_ready (stg_ready[NUM_STAGES]),
    .in_data  (stg_data[NUM_STAGES]),
    .dout     (dout)
  );

endmodule

### rtl/core/sitda_checker.sv
// Port-level checks of the converter's output channel, bound to the top level.
module sitda_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sitda_pkg::CHAR_W-1:0]   character,
  input logic                           last
);
  import sitda_pkg::*;

  // Nothing leaves in the cycle after a reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Every character is a minus sign or a decimal digit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == ASCII_MINUS) ||
                  ((character >= ASCII_ZERO) && (character <= ASCII_NINE)))
    else $error("character outside the decimal alphabet");

  // A minus sign never ends a run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (character == ASCII_MINUS)) |-> !last)
    else $error("run ends on a minus sign");

  // A stalled character is held unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last)))
    else $error("stalled output item changed");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .character (dout.character),
  .last      (dout.last)
);
